### sv/assert_macros.svh
// Shared assertion macros; each module names its clock clk and its reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/mfa_pkg.sv
`default_nettype none
package mfa_pkg;

    localparam int W = 16;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_MUL = 2'd1;
    localparam logic [1:0] MODE_DIV = 2'd2;
    localparam logic [1:0] MODE_INV = 2'd3;

    localparam logic [1:0] RED_A = 2'd0;
    localparam logic [1:0] RED_B = 2'd1;
    localparam logic [1:0] RED_P = 2'd2;

    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_ADD  = 2'd1;
    localparam logic [1:0] RES_REM  = 2'd2;
    localparam logic [1:0] RES_INV  = 2'd3;

    localparam logic [W-1:0] MODULUS_RESET = 16'd5;

    typedef struct packed {
        logic [1:0]   mode;
        logic [W-1:0] operand_a;
        logic [W-1:0] operand_b;
    } in_t;

    typedef struct packed {
        logic [W-1:0] result;
        logic         error;
    } out_t;

    typedef struct packed {
        logic       load;
        logic       red_start;
        logic [1:0] red_sel;
        logic       red_step;
        logic       store_a;
        logic       store_b;
        logic       mul;
        logic       eu_init;
        logic       eu_begin;
        logic       eu_step;
        logic       inv_store;
        logic       res_wr;
        logic [1:0] res_sel;
        logic       res_err;
        logic       out_push;
    } mfa_cmd_t;

    typedef struct packed {
        logic       m_small;
        logic       red_done;
        logic       r1_zero;
        logic       sh_zero;
        logic       eu_ok;
        logic [1:0] mode;
    } mfa_stat_t;

    function automatic logic [4:0] lead_zeros(input logic [W-1:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'(W);
        found = 1'b0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n = 5'(W - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### sv/mfa_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module mfa_ctrl
    import mfa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire mfa_stat_t stat,
    output mfa_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_REDA  = 4'd2;
    localparam logic [3:0] S_REDB  = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_PRS   = 4'd6;
    localparam logic [3:0] S_REDP  = 4'd7;
    localparam logic [3:0] S_EUI   = 4'd8;
    localparam logic [3:0] S_EUB   = 4'd9;
    localparam logic [3:0] S_EUS   = 4'd10;
    localparam logic [3:0] S_EUF   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.m_small)
                begin
                    cmd.res_wr  = 1'b1;
                    cmd.res_sel = RES_ZERO;
                    cmd.res_err = (stat.mode == MODE_DIV) || (stat.mode == MODE_INV);
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.red_start = 1'b1;
                    cmd.red_sel   = RED_A;
                    state_next    = S_REDA;
                end
            end
            S_REDA:
            begin
                if (stat.red_done)
                begin
                    cmd.store_a   = 1'b1;
                    cmd.red_start = 1'b1;
                    cmd.red_sel   = RED_B;
                    state_next    = S_REDB;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_REDB:
            begin
                if (stat.red_done)
                begin
                    cmd.store_b = 1'b1;
                    unique case (stat.mode)
                        MODE_ADD: state_next = S_ADD;
                        MODE_MUL: state_next = S_MUL;
                        default:  state_next = S_EUI;
                    endcase
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_ADD:
            begin
                cmd.res_wr  = 1'b1;
                cmd.res_sel = RES_ADD;
                state_next  = S_DONE;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PRS;
            end
            S_PRS:
            begin
                cmd.red_start = 1'b1;
                cmd.red_sel   = RED_P;
                state_next    = S_REDP;
            end
            S_REDP:
            begin
                if (stat.red_done)
                begin
                    cmd.res_wr  = 1'b1;
                    cmd.res_sel = RES_REM;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_EUI:
            begin
                cmd.eu_init = 1'b1;
                state_next  = S_EUB;
            end
            S_EUB:
            begin
                if (stat.r1_zero)
                begin
                    state_next = S_EUF;
                end
                else
                begin
                    cmd.eu_begin = 1'b1;
                    state_next   = S_EUS;
                end
            end
            S_EUS:
            begin
                cmd.eu_step = 1'b1;
                if (stat.sh_zero)
                begin
                    state_next = S_EUB;
                end
            end
            S_EUF:
            begin
                if (!stat.eu_ok)
                begin
                    cmd.res_wr  = 1'b1;
                    cmd.res_sel = RES_ZERO;
                    cmd.res_err = 1'b1;
                    state_next  = S_DONE;
                end
                else if (stat.mode == MODE_INV)
                begin
                    cmd.res_wr  = 1'b1;
                    cmd.res_sel = RES_INV;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.inv_store = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPL(a_push_free, cmd.out_push, !out_valid_reg || !out_stall)
    `ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state_reg == S_CHECK)
    `ASSERT_IMPL(a_stall_held, out_valid_reg && out_stall, out_valid_next)

endmodule
`default_nettype wire

### sv/mfa_dp.sv
`default_nettype none
`include "assert_macros.svh"
module mfa_dp
    import mfa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [W-1:0] cfg_wdata,
    input  wire in_t          in_data,
    input  wire mfa_cmd_t     cmd,
    output mfa_stat_t         stat,
    output out_t              out_data
);

    logic [W-1:0]   m_reg;
    logic [1:0]     mode_reg;
    logic [W-1:0]   a_reg, b_reg;
    logic [2*W-1:0] x_reg;
    logic [W-1:0]   rem_reg;
    logic [5:0]     cnt_reg;
    logic [2*W-1:0] prod_reg;
    logic [W-1:0]   inv_reg;
    logic [W-1:0]   r0_reg, r1_reg, rw_reg;
    logic signed [33:0] t0_reg, t1_reg, tw_reg;
    logic [3:0]     sh_reg;
    logic [W-1:0]   res_reg;
    logic           err_reg;
    out_t           out_reg;

    logic [W:0]         red_t, red_nx;
    logic [4:0]         sh_diff;
    logic [2*W-1:0]     d_shift;
    logic signed [33:0] t_shift;
    logic               fits;
    logic [W-1:0]       rw_next;
    logic signed [33:0] tw_next;
    logic signed [33:0] t_pos, t_fix, m_wide;
    logic [W:0]         sum, sum_red;
    logic [W-1:0]       mul_op;
    logic [W-1:0]       res_next;

    assign red_t   = {rem_reg, x_reg[2*W-1]};
    assign red_nx  = (red_t >= {1'b0, m_reg}) ? red_t - {1'b0, m_reg} : red_t;
    assign sh_diff = lead_zeros(r1_reg) - lead_zeros(r0_reg);
    assign d_shift = {{W{1'b0}}, r1_reg} << sh_reg;
    assign t_shift = t1_reg <<< sh_reg;
    assign fits    = d_shift <= {{W{1'b0}}, rw_reg};
    assign rw_next = fits ? rw_reg - d_shift[W-1:0] : rw_reg;
    assign tw_next = fits ? tw_reg - t_shift : tw_reg;
    assign m_wide  = $signed({{(34-W){1'b0}}, m_reg});
    assign t_pos   = t0_reg[33] ? t0_reg + m_wide : t0_reg;
    assign t_fix   = (t_pos >= m_wide) ? t_pos - m_wide : t_pos;
    assign sum     = {1'b0, a_reg} + {1'b0, b_reg};
    assign sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
    assign mul_op  = (mode_reg == MODE_DIV) ? inv_reg : b_reg;

    always_comb
    begin
        case (cmd.res_sel)
            RES_ADD: res_next = sum_red[W-1:0];
            RES_REM: res_next = rem_reg;
            RES_INV: res_next = t_fix[W-1:0];
            default: res_next = '0;
        endcase
    end

    assign stat.m_small  = m_reg < 16'd2;
    assign stat.red_done = cnt_reg == 6'd0;
    assign stat.r1_zero  = r1_reg == '0;
    assign stat.sh_zero  = sh_reg == 4'd0;
    assign stat.eu_ok    = r0_reg == 16'd1;
    assign stat.mode     = mode_reg;
    assign out_data      = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg   <= MODULUS_RESET;
            cnt_reg <= 6'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                m_reg <= cfg_wdata;
            end
            if (cmd.red_start)
            begin
                cnt_reg <= (cmd.red_sel == RED_P) ? 6'd32 : 6'd16;
            end
            else if (cmd.red_step)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_data.mode;
            a_reg    <= in_data.operand_a;
            b_reg    <= in_data.operand_b;
        end
        if (cmd.store_a)
        begin
            a_reg <= rem_reg;
        end
        if (cmd.store_b)
        begin
            b_reg <= rem_reg;
        end
        if (cmd.red_start)
        begin
            rem_reg <= '0;
            case (cmd.red_sel)
                RED_A:   x_reg <= {a_reg, {W{1'b0}}};
                RED_B:   x_reg <= {b_reg, {W{1'b0}}};
                default: x_reg <= prod_reg;
            endcase
        end
        else if (cmd.red_step)
        begin
            rem_reg <= red_nx[W-1:0];
            x_reg   <= {x_reg[2*W-2:0], 1'b0};
        end
        if (cmd.mul)
        begin
            prod_reg <= a_reg * mul_op;
        end
        if (cmd.eu_init)
        begin
            r0_reg <= m_reg;
            r1_reg <= (mode_reg == MODE_INV) ? a_reg : b_reg;
            t0_reg <= 34'sd0;
            t1_reg <= 34'sd1;
        end
        if (cmd.eu_begin)
        begin
            rw_reg <= r0_reg;
            tw_reg <= t0_reg;
            sh_reg <= (r0_reg >= r1_reg) ? sh_diff[3:0] : 4'd0;
        end
        if (cmd.eu_step)
        begin
            if (sh_reg == 4'd0)
            begin
                r0_reg <= r1_reg;
                r1_reg <= rw_next;
                t0_reg <= t1_reg;
                t1_reg <= tw_next;
            end
            else
            begin
                rw_reg <= rw_next;
                tw_reg <= tw_next;
                sh_reg <= sh_reg - 4'd1;
            end
        end
        if (cmd.inv_store)
        begin
            inv_reg <= t_fix[W-1:0];
        end
        if (cmd.res_wr)
        begin
            res_reg <= res_next;
            err_reg <= cmd.res_err;
        end
        if (cmd.out_push)
        begin
            out_reg.result <= res_reg;
            out_reg.error  <= err_reg;
        end
    end

    `ASSERT_NEXT(a_red_count, cmd.red_step && !cmd.red_start, cnt_reg == $past(cnt_reg) - 6'd1)
    `ASSERT_NEXT(a_res_range, cmd.res_wr, res_reg == '0 || res_reg < m_reg)
    `ASSERT_NEXT(a_err_zero, cmd.res_wr && cmd.res_err, res_reg == '0)

endmodule
`default_nettype wire

### sv/modular_field_alu_core.sv
`default_nettype none
// The Euclid loop of inverse and divide takes a step per quotient and per quotient
//   bit; divide runs that inverse and then a multiply with product reduction.
// Throughput: one request at a time; set by the one-bit-per-cycle modular
//   reducer and the shift-subtract Euclid step.
// Reset: rst_n is asynchronous, active low; modulus returns to 5, channels go idle.
module modular_field_alu_core
    import mfa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire in_t          in_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output out_t              out_data,
    input  wire logic         cfg_we,
    input  wire logic [W-1:0] cfg_wdata
);

    mfa_cmd_t  cmd;
    mfa_stat_t stat;

    mfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mfa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mfa_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_REQUESTS = 1600;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    in_t          in_data;
    logic         out_valid;
    logic         out_stall;
    out_t         out_data;
    logic         cfg_we;
    logic [W-1:0] cfg_wdata;

    in_t          pending_requests[$];
    out_t         expected_results[$];
    logic [W-1:0] field_modulus;
    int           mismatch_count;
    int           idle_cycles;
    bit           sender_hold;

    modular_field_alu_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic bit find_inverse(input longint unsigned x, input longint unsigned m,
                                        output longint unsigned inv);
        longint unsigned r0;
        longint unsigned r1;
        longint unsigned q;
        longint unsigned rn;
        longint          t0;
        longint          t1;
        longint          tn;
        r0 = m;
        r1 = x;
        t0 = 0;
        t1 = 1;
        inv = 0;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            rn = r0 - q * r1;
            tn = t0 - longint'(q) * t1;
            r0 = r1;
            r1 = rn;
            t0 = t1;
            t1 = tn;
        end
        if (r0 != 1)
            return 1'b0;
        if (t0 < 0)
            t0 += longint'(m);
        inv = longint'(t0) % m;
        return 1'b1;
    endfunction

    function automatic out_t field_result(input in_t req, input logic [W-1:0] modv);
        out_t            res;
        longint unsigned m;
        longint unsigned a;
        longint unsigned b;
        longint unsigned inv;
        longint unsigned value;
        m = modv;
        value = 0;
        res.error = 1'b0;
        if (m < 2)
        begin
            res.error = (req.mode == MODE_DIV || req.mode == MODE_INV);
        end
        else
        begin
            a = req.operand_a % m;
            b = req.operand_b % m;
            case (req.mode)
                MODE_ADD: value = (a + b) % m;
                MODE_MUL: value = (a * b) % m;
                MODE_DIV:
                    if (find_inverse(b, m, inv))
                        value = (a * inv) % m;
                    else
                        res.error = 1'b1;
                default:
                    if (find_inverse(a, m, inv))
                        value = inv;
                    else
                        res.error = 1'b1;
            endcase
        end
        res.result = value[W-1:0];
        return res;
    endfunction

    function automatic logic [W-1:0] random_operand(input logic [W-1:0] modv);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'hFFFF;
            2: return modv;
            3: return W'($urandom_range(0, 3));
            default: return W'($urandom());
        endcase
    endfunction

    task automatic queue_request(input logic [1:0] mode, input logic [W-1:0] a,
                                 input logic [W-1:0] b);
        in_t req;
        req.mode = mode;
        req.operand_a = a;
        req.operand_b = b;
        pending_requests.push_back(req);
    endtask

    task automatic drain();
        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        field_modulus <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_results.push_back(field_result(in_data, field_modulus));
            if (pending_requests.size() != 0 && !sender_hold && gap_length() == 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_requests.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h error %b",
                                 out_data.result, out_data.error);
                end
                else
                begin
                    out_t want;
                    want = expected_results.pop_front();
                    if (out_data.result !== want.result || out_data.error !== want.error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected result %h error %b, got %h error %b",
                                     want.result, want.error, out_data.result, out_data.error);
                    end
                end
            end
            out_stall <= (gap_length() != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [W-1:0] moduli[10];
        logic [W-1:0] dwidth_mod;
        int           phase;
        moduli = '{16'd7, 16'd65521, 16'd65535, 16'd2, 16'd12, 16'd0, 16'd1,
                   16'd257, 16'd32768, 16'd40009};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        field_modulus = MODULUS_RESET;
        mismatch_count = 0;
        idle_cycles = 0;
        sender_hold = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests under the reset modulus
        for (int mode = 0; mode < 4; mode++)
        begin
            queue_request(2'(mode), 16'h0000, 16'h0000);
            queue_request(2'(mode), 16'hFFFF, 16'hFFFF);
            queue_request(2'(mode), 16'd3, 16'd4);
            queue_request(2'(mode), 16'd5, 16'd10);
        end
        queue_request(MODE_DIV, 16'd0, 16'd2);
        queue_request(MODE_DIV, 16'd7, 16'd0);
        queue_request(MODE_INV, 16'd1, 16'hAAAA);
        queue_request(MODE_ADD, 16'h5555, 16'hAAAA);
        drain();

        for (phase = 0; phase < 10; phase++)
        begin
            dwidth_mod = moduli[phase];
            write_modulus(dwidth_mod);
            queue_request(MODE_INV, dwidth_mod - 16'd1, 16'd0);
            queue_request(MODE_DIV, 16'd0, 16'd1);
            queue_request(MODE_MUL, dwidth_mod - 16'd1, dwidth_mod - 16'd1);
            for (int i = 0; i < RANDOM_REQUESTS / 10; i++)
                queue_request(2'($urandom_range(0, 3)), random_operand(dwidth_mod),
                              random_operand(dwidth_mod));
            if (phase == 4)
            begin
                wait (pending_requests.size() < 80);
                sender_hold = 1'b1;
                wait (!in_valid && expected_results.size() == 0);
                sender_hold = 1'b0;
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
